// File: rtl/centered_image_to_framebuffer_writer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the centered image framebuffer writer
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CENTERED_IMAGE_TO_FRAMEBUFFER_WRITER_ASSERT_SVH
`define CENTERED_IMAGE_TO_FRAMEBUFFER_WRITER_ASSERT_SVH

// same-cycle implication
`define CIFW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CIFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cifw_pkg.sv
// ----------------------------------------------------------------------------
// cifw_pkg
// Types, register indexes and pixel conversion for the framebuffer writer.
// ----------------------------------------------------------------------------
`default_nettype none

package cifw_pkg;

  localparam int RUN_W     = 23;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FORMAT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IN_FORMAT    = 3'd5;

  // reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd1200;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd900;
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd1200;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd900;

  // format codes
  localparam logic OUT_RGB565 = 1'b0;
  localparam logic IN_GREY    = 1'b0;

  // conversion constants
  localparam logic [7:0]  LOW3_MASK  = 8'h07;
  localparam logic [7:0]  LOW2_MASK  = 8'h03;
  localparam logic [7:0]  RB_BIAS    = 8'h03;
  localparam logic [7:0]  G_BIAS     = 8'h01;
  localparam logic [7:0]  RB_KEEP    = 8'hF8;
  localparam logic [7:0]  G_KEEP     = 8'hFC;
  localparam logic [31:0] ALPHA_FULL = 32'hff000000;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic             out_format;
    logic             in_format;
  } cfg_t;

  typedef struct packed {
    logic [31:0]      pix;
    logic [31:0]      fill;
    logic [RUN_W-1:0] top_run;
    logic             top_nz;
    logic [RUN_W-1:0] gap_run;
    logic             gap_nz;
    logic [RUN_W-1:0] bot_run;
    logic             bot_nz;
    logic             first;
    logic             row_end;
    logic             frame_end;
  } run_entry_t;

  function automatic logic [31:0] conv_pixel(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] c2, input logic in_fmt,
                                             input logic out_fmt);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] rr;
    logic [7:0] gg;
    logic [7:0] bb;
    r  = c0;
    g  = (in_fmt == IN_GREY) ? c0 : c1;
    b  = (in_fmt == IN_GREY) ? c0 : c2;
    rr = (r | ((r & LOW3_MASK) + RB_BIAS)) & RB_KEEP;
    gg = (g | ((g & LOW2_MASK) + G_BIAS)) & G_KEEP;
    bb = b | ((b & LOW3_MASK) + RB_BIAS);
    if (out_fmt == OUT_RGB565) begin
      conv_pixel = {16'd0, rr[7:3], gg[7:2], bb[7:3]};
    end else begin
      conv_pixel = ALPHA_FULL | {8'd0, r, g, b};
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/cifw_front.sv
// ----------------------------------------------------------------------------
// cifw_front
// Accepts pixels, converts them, tracks raster position and works out the
// margin runs over two register stages before pushing a run entry.
// ----------------------------------------------------------------------------
`default_nettype none

module cifw_front import cifw_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         chan0,
  input  wire logic [7:0]         chan1,
  input  wire logic [7:0]         chan2,
  input  wire logic [Q_CNT_W-1:0] q_level,
  output logic                    push,
  output run_entry_t              entry
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW;
  localparam int MW = PW + 1;

  logic [WW-1:0] fw_c, iw_c, gap_w, left;
  logic [HW-1:0] fh_c, ih_c, gap_h, top, bottom;
  logic [WW-1:0] column_count, col_inc;
  logic [HW-1:0] row_count, row_inc;
  logic          first_pending;
  logic [31:0]   fill_word;
  logic [31:0]   pix;
  logic          accept, row_end, frame_end;
  logic [Q_CNT_W-1:0] occ;

  // stage 1
  logic          v1;
  logic [31:0]   pix1, fill1;
  logic          first1, row_end1, frame_end1;
  logic [WW-1:0] fw1, gap1, left1;
  logic [HW-1:0] top1, bot1;

  // stage 2
  logic          v2;
  logic [31:0]   pix2, fill2;
  logic          first2, row_end2, frame_end2;
  logic [WW-1:0] gap2, left2;
  logic [PW-1:0] prod_top, prod_bot;

  logic [MW-1:0] m_top;
  logic [PW-1:0] m_bot;

  // clamp register values into the legal dimension range
  always_comb begin
    if (cfg.frame_width == '0) fw_c = WW'(1);
    else if (32'(cfg.frame_width) > MAX_WIDTH) fw_c = WW'(MAX_WIDTH);
    else fw_c = WW'(cfg.frame_width);
    if (cfg.image_width == '0) iw_c = WW'(1);
    else if (32'(cfg.image_width) > MAX_WIDTH) iw_c = WW'(MAX_WIDTH);
    else iw_c = WW'(cfg.image_width);
    if (cfg.frame_height == '0) fh_c = HW'(1);
    else if (32'(cfg.frame_height) > MAX_HEIGHT) fh_c = HW'(MAX_HEIGHT);
    else fh_c = HW'(cfg.frame_height);
    if (cfg.image_height == '0) ih_c = HW'(1);
    else if (32'(cfg.image_height) > MAX_HEIGHT) ih_c = HW'(MAX_HEIGHT);
    else ih_c = HW'(cfg.image_height);
  end

  always_comb begin
    gap_w  = (fw_c > iw_c) ? fw_c - iw_c : '0;
    gap_h  = (fh_c > ih_c) ? fh_c - ih_c : '0;
    left   = gap_w >> 1;
    top    = gap_h >> 1;
    bottom = gap_h - top;
  end

  always_comb begin
    pix       = conv_pixel(chan0, chan1, chan2, cfg.in_format, cfg.out_format);
    col_inc   = column_count + WW'(1);
    row_inc   = row_count + HW'(1);
    row_end   = (col_inc >= iw_c);
    frame_end = row_end && (row_inc >= ih_c);
  end

  // leave room in the queue for every word still in the two stages
  assign occ      = q_level + Q_CNT_W'(v1) + Q_CNT_W'(v2);
  assign in_ready = (occ < Q_CNT_W'(Q_DEPTH));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      first_pending <= 1'b1;
      fill_word     <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      if (accept) begin
        if (first_pending) begin
          fill_word <= pix;
        end
        if (frame_end) begin
          column_count  <= '0;
          row_count     <= '0;
          first_pending <= 1'b1;
        end else if (row_end) begin
          column_count  <= '0;
          row_count     <= row_inc;
          first_pending <= 1'b0;
        end else begin
          column_count  <= col_inc;
          first_pending <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pix1       <= pix;
    fill1      <= first_pending ? pix : fill_word;
    first1     <= first_pending;
    row_end1   <= row_end;
    frame_end1 <= frame_end;
    fw1        <= fw_c;
    gap1       <= gap_w;
    left1      <= left;
    top1       <= top;
    bot1       <= bottom;

    pix2       <= pix1;
    fill2      <= fill1;
    first2     <= first1;
    row_end2   <= row_end1;
    frame_end2 <= frame_end1;
    gap2       <= gap1;
    left2      <= left1;
    prod_top   <= PW'(top1) * PW'(fw1);
    prod_bot   <= PW'(bot1) * PW'(fw1);
  end

  always_comb begin
    m_top = MW'(prod_top) + MW'(left2);
    if (prod_bot > PW'(left2)) m_bot = prod_bot - PW'(left2);
    else m_bot = '0;
  end

  always_comb begin
    entry.pix       = pix2;
    entry.fill      = fill2;
    entry.top_run   = RUN_W'(m_top);
    entry.top_nz    = (m_top != '0);
    entry.gap_run   = RUN_W'(gap2);
    entry.gap_nz    = (gap2 != '0);
    entry.bot_run   = RUN_W'(m_bot);
    entry.bot_nz    = (m_bot != '0);
    entry.first     = first2;
    entry.row_end   = row_end2;
    entry.frame_end = frame_end2;
  end

  assign push = v2;

endmodule

`default_nettype wire

// File: rtl/cifw_queue.sv
// ----------------------------------------------------------------------------
// cifw_queue
// Short FIFO of run entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cifw_queue import cifw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire run_entry_t         din,
  input  wire logic               pop,
  output run_entry_t              dout,
  output logic [Q_CNT_W-1:0]      level
);

  run_entry_t         slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (push && !pop) level <= level + Q_CNT_W'(1);
      else if (pop && !push) level <= level - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  assign dout = slots[rd_ptr];

endmodule

`default_nettype wire

// File: rtl/cifw_back.sv
// ----------------------------------------------------------------------------
// cifw_back
// Walks each entry through its runs (top margin, pixel, row gap, bottom)
// and drives the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module cifw_back import cifw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire run_entry_t       head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           fb_word,
  output logic [RUN_W-1:0]      repeat_count,
  output logic                  frame_done
);

  typedef enum logic [1:0] {
    P_TOP,
    P_PIX,
    P_GAP,
    P_BOT
  } phase_t;

  phase_t           ph, eff, nxt;
  logic             app_top, app_gap, app_bot, last, load;
  logic [31:0]      word;
  logic [RUN_W-1:0] count;

  always_comb begin
    app_top = head.first && head.top_nz;
    app_gap = head.row_end && head.gap_nz;
    app_bot = head.frame_end && head.bot_nz;
    // ph holds only a phase that applies, or the top phase of a fresh entry
    eff = (ph == P_TOP && !app_top) ? P_PIX : ph;
    nxt  = P_TOP;
    last = 1'b1;
    case (eff)
      P_TOP: begin
        nxt  = P_PIX;
        last = 1'b0;
      end
      P_PIX: begin
        if (app_gap) begin
          nxt  = P_GAP;
          last = 1'b0;
        end else if (app_bot) begin
          nxt  = P_BOT;
          last = 1'b0;
        end
      end
      P_GAP: begin
        if (app_bot) begin
          nxt  = P_BOT;
          last = 1'b0;
        end
      end
      default: begin
        nxt  = P_TOP;
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (eff)
      P_TOP: begin
        word  = head.fill;
        count = head.top_run;
      end
      P_PIX: begin
        word  = head.pix;
        count = RUN_W'(1);
      end
      P_GAP: begin
        word  = head.fill;
        count = head.gap_run;
      end
      default: begin
        word  = head.fill;
        count = head.bot_run;
      end
    endcase
  end

  assign load = q_valid && (!out_valid || out_ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= P_TOP;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid    <= 1'b1;
        fb_word      <= word;
        repeat_count <= count;
        frame_done   <= last && head.frame_end;
        ph           <= last ? P_TOP : nxt;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/centered_image_to_framebuffer_writer.sv
// Path: a word passes the two front register stages, the run queue and the
// output word register. Throughput: one pixel per cycle while each pixel yields
// one run and out_ready holds; a pixel that also closes a row or starts or ends
// the frame yields one word per run (up to 4) from the single output register.
// Reset: registers return to their defaults, raster counters clear, the queue
// empties and the next pixel starts a new frame.
// ----------------------------------------------------------------------------
// centered_image_to_framebuffer_writer
// Places an image in the middle of a framebuffer and emits it as runs.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_image_to_framebuffer_writer import cifw_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           chan0,
  input  wire logic [7:0]           chan1,
  input  wire logic [7:0]           chan2,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               fb_word,
  output logic [RUN_W-1:0]          repeat_count,
  output logic                      frame_done
);

  cfg_t               cfg;
  logic               q_push, q_pop;
  run_entry_t         q_din, q_dout;
  logic [Q_CNT_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= RST_FRAME_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.out_format   <= OUT_RGB565;
      cfg.in_format    <= ~IN_GREY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        REG_OUT_FORMAT:   cfg.out_format   <= cfg_data[0];
        REG_IN_FORMAT:    cfg.in_format    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cifw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .chan0    (chan0),
    .chan1    (chan1),
    .chan2    (chan2),
    .q_level  (q_level),
    .push     (q_push),
    .entry    (q_din)
  );

  cifw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .level (q_level)
  );

  cifw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_level != '0),
    .head         (q_dout),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fb_word      (fb_word),
    .repeat_count (repeat_count),
    .frame_done   (frame_done)
  );

`include "centered_image_to_framebuffer_writer_assert.svh"

  `CIFW_ASSERT_IMP(a_no_overflow, q_push && !q_pop, q_level != Q_CNT_W'(Q_DEPTH),
    "run queue overflow")
  `CIFW_ASSERT_IMP(a_no_underflow, q_pop, q_level != '0, "run queue underflow")
  `CIFW_ASSERT_NEXT(a_pop_drains, q_pop && !q_push,
    q_level == $past(q_level) - Q_CNT_W'(1), "queue level did not drop on pop")

endmodule

`default_nettype wire

// File: tb/tb_centered_image_to_framebuffer_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_centered_image_to_framebuffer_writer
// Streams pixels into the letterbox run writer and scores every run word against
// a cycle-free model of the margins, fill value and pixel packing, or a known word.
// ----------------------------------------------------------------------------

module tb_centered_image_to_framebuffer_writer;
  import cifw_pkg::*;

  localparam int unsigned FB_MAX_W = 2048;
  localparam int unsigned FB_MAX_H = 2048;
  localparam int unsigned RANDOM_PIXELS = 480;

  typedef struct packed {
    logic [31:0]      word;
    logic [RUN_W-1:0] count;
    logic             done;
  } run_t;

  typedef enum bit [1:0] {ROW_REG, ROW_PIX, ROW_KNOWN} row_kind_t;

  // ROW_KNOWN rows run on a 1x1 frame: one run of 1 that closes the frame
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [7:0]           c0;
    logic [7:0]           c1;
    logic [7:0]           c2;
    logic [31:0]          word;
  } step_t;

  localparam int N_DIRECTED = 34;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    // all dimensions zero: everything collapses to 1x1
    '{ROW_REG,   REG_FRAME_WIDTH,  12'd0,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_REG,   REG_FRAME_HEIGHT, 12'd0,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_REG,   REG_IMAGE_WIDTH,  12'd0,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 12'd0,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_KNOWN, REG_FRAME_WIDTH,  12'd0,   8'hff, 8'hff, 8'hff, 32'h0000ffff},
    '{ROW_KNOWN, REG_FRAME_WIDTH,  12'd0,   8'h00, 8'h00, 8'h00, 32'h00000000},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h05, 8'h02, 8'hfe, 32'h0},
    '{ROW_REG,   REG_OUT_FORMAT,   12'd1,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_KNOWN, REG_FRAME_WIDTH,  12'd0,   8'h00, 8'h00, 8'h00, 32'hff000000},
    '{ROW_KNOWN, REG_FRAME_WIDTH,  12'd0,   8'h12, 8'h34, 8'h56, 32'hff123456},
    // upper format bits set, only bit 0 counts
    '{ROW_REG,   REG_IN_FORMAT,    12'hffe, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_KNOWN, REG_FRAME_WIDTH,  12'd0,   8'h80, 8'h11, 8'h22, 32'hff808080},
    '{ROW_REG,   REG_OUT_FORMAT,   12'hffe, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_KNOWN, REG_FRAME_WIDTH,  12'd0,   8'hff, 8'h00, 8'h00, 32'h0000ffff},
    '{ROW_REG,   REG_IN_FORMAT,    12'hfff, 8'h00, 8'h00, 8'h00, 32'h0},
    // image bigger than the frame
    '{ROW_REG,   REG_IMAGE_WIDTH,  12'd2,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 12'd2,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h01, 8'hfe, 8'h7f, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h80, 8'h40, 8'hc3, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h3c, 8'h99, 8'h08, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'hf8, 8'hfc, 8'h07, 32'h0},
    // frame above the maximum clamps to full size
    '{ROW_REG,   REG_FRAME_WIDTH,  12'hfff, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_REG,   REG_FRAME_HEIGHT, 12'hfff, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h5a, 8'ha5, 8'h11, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h07, 8'h03, 8'hfb, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h00, 8'hff, 8'h00, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'hff, 8'h00, 8'hff, 32'h0},
    // shrink the image in the middle of a frame
    '{ROW_REG,   REG_IMAGE_WIDTH,  12'hfff, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 12'hfff, 8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h9e, 8'h61, 8'h2d, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'h44, 8'hbb, 8'h70, 32'h0},
    '{ROW_REG,   REG_IMAGE_WIDTH,  12'd3,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 12'd1,   8'h00, 8'h00, 8'h00, 32'h0},
    '{ROW_PIX,   REG_FRAME_WIDTH,  12'd0,   8'he3, 8'h1c, 8'h86, 32'h0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           chan0 = '0;
  logic [7:0]           chan1 = '0;
  logic [7:0]           chan2 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          fb_word;
  logic [RUN_W-1:0]     repeat_count;
  logic                 frame_done;

  centered_image_to_framebuffer_writer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .chan0        (chan0),
    .chan1        (chan1),
    .chan2        (chan2),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fb_word      (fb_word),
    .repeat_count (repeat_count),
    .frame_done   (frame_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // model state and register shadow
  logic [CFG_W-1:0] reg_val [6];
  int unsigned      col_pos;
  int unsigned      row_pos;
  bit               frame_start;
  logic [31:0]      fill_word;
  run_t             fresh_runs [$];
  run_t             runs_due [$];

  int  errors = 0;
  int  pix_sent = 0;
  bit  steady = 1'b0;
  run_t want;

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned dim_eff(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic logic [31:0] pixel_word(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] c2);
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    r = {24'd0, c0};
    g = (reg_val[REG_IN_FORMAT][0] == IN_GREY) ? r : {24'd0, c1};
    b = (reg_val[REG_IN_FORMAT][0] == IN_GREY) ? r : {24'd0, c2};
    if (reg_val[REG_OUT_FORMAT][0] == OUT_RGB565)
      return (((r | ((r & LOW3_MASK) + RB_BIAS)) & RB_KEEP) << 8)
           | (((g | ((g & LOW2_MASK) + G_BIAS)) & G_KEEP) << 3)
           | ((b | ((b & LOW3_MASK) + RB_BIAS)) >> 3);
    return ALPHA_FULL | (r << 16) | (g << 8) | b;
  endfunction

  function automatic void add_run(input logic [31:0] word, input longint unsigned n);
    run_t r;
    r.word  = word;
    r.count = n[RUN_W-1:0];
    r.done  = 1'b0;
    fresh_runs.push_back(r);
  endfunction

  // runs caused by one pixel, left in fresh_runs
  function automatic void predict_runs(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2);
    int unsigned       fw;
    int unsigned       fh;
    int unsigned       iw;
    int unsigned       ih;
    int unsigned       gap_w;
    int unsigned       gap_h;
    int unsigned       left_cols;
    int unsigned       top_rows;
    longint unsigned   span;
    logic [31:0]       px;
    fw = dim_eff(reg_val[REG_FRAME_WIDTH], FB_MAX_W);
    fh = dim_eff(reg_val[REG_FRAME_HEIGHT], FB_MAX_H);
    iw = dim_eff(reg_val[REG_IMAGE_WIDTH], FB_MAX_W);
    ih = dim_eff(reg_val[REG_IMAGE_HEIGHT], FB_MAX_H);
    gap_w = (fw > iw) ? fw - iw : 0;
    gap_h = (fh > ih) ? fh - ih : 0;
    left_cols = gap_w / 2;
    top_rows = gap_h / 2;
    px = pixel_word(c0, c1, c2);
    fresh_runs.delete();
    if (frame_start) begin
      fill_word = px;
      frame_start = 1'b0;
      span = 64'(top_rows) * 64'(fw) + 64'(left_cols);
      if (span != 0) add_run(fill_word, span);
    end
    add_run(px, 1);
    col_pos++;
    if (col_pos >= iw) begin
      col_pos = 0;
      if (gap_w != 0) add_run(fill_word, gap_w);
      row_pos++;
      if (row_pos >= ih) begin
        span = 64'(gap_h - top_rows) * 64'(fw);
        span = (span > left_cols) ? span - left_cols : 0;
        if (span != 0) add_run(fill_word, span);
        fresh_runs[fresh_runs.size() - 1].done = 1'b1;
        row_pos = 0;
        frame_start = 1'b1;
      end
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    reg_val[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and wait until the pipeline has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
                            input bit known, input logic [31:0] known_word);
    run_t r;
    if (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 36);
    end
    in_valid <= 1'b1;
    chan0    <= c0;
    chan1    <= c1;
    chan2    <= c2;
    do @(posedge clk); while (in_ready !== 1'b1);
    pix_sent++;
    predict_runs(c0, c1, c2);
    if (known) begin
      r.word  = known_word;
      r.count = RUN_W'(1);
      r.done  = 1'b1;
      runs_due.push_back(r);
    end else begin
      foreach (fresh_runs[k]) runs_due.push_back(fresh_runs[k]);
    end
  endtask

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 36);

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (runs_due.size() == 0) begin
        note_error($sformatf("unexpected word %h count %0d done %b",
                             fb_word, repeat_count, frame_done));
      end else begin
        want = runs_due.pop_front();
        if (fb_word !== want.word || repeat_count !== want.count || frame_done !== want.done)
          note_error($sformatf("exp word %h count %0d done %b, got word %h count %0d done %b",
                               want.word, want.count, want.done,
                               fb_word, repeat_count, frame_done));
      end
    end
  end

  initial begin
    int unsigned target;
    int unsigned n;
    bit          big;
    reg_val[REG_FRAME_WIDTH]  = RST_FRAME_WIDTH;
    reg_val[REG_FRAME_HEIGHT] = RST_FRAME_HEIGHT;
    reg_val[REG_IMAGE_WIDTH]  = RST_IMAGE_WIDTH;
    reg_val[REG_IMAGE_HEIGHT] = RST_IMAGE_HEIGHT;
    reg_val[REG_OUT_FORMAT]   = '0;
    reg_val[REG_IN_FORMAT]    = 12'd1;
    col_pos = 0;
    row_pos = 0;
    frame_start = 1'b1;
    fill_word = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        settle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        send_pixel(DIRECTED[i].c0, DIRECTED[i].c1, DIRECTED[i].c2,
                   DIRECTED[i].kind == ROW_KNOWN, DIRECTED[i].word);
      end
    end

    target = pix_sent + RANDOM_PIXELS;
    while (pix_sent < target) begin
      settle();
      steady = (pix_sent >= 200 && pix_sent < 290);
      big = ($urandom_range(7) == 0);
      if ($urandom_range(3) != 0)
        write_reg(REG_FRAME_WIDTH, big ? CFG_W'($urandom_range(4095))
                                       : CFG_W'($urandom_range(12)));
      if ($urandom_range(3) != 0)
        write_reg(REG_FRAME_HEIGHT, big ? CFG_W'($urandom_range(4095))
                                        : CFG_W'($urandom_range(10)));
      if ($urandom_range(3) != 0) write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(6)));
      if ($urandom_range(3) != 0) write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(5)));
      if ($urandom_range(1) != 0) write_reg(REG_OUT_FORMAT, CFG_W'($urandom_range(4095)));
      if ($urandom_range(1) != 0) write_reg(REG_IN_FORMAT, CFG_W'($urandom_range(4095)));
      if ($urandom_range(9) == 0) begin
        // cut the frame short, the next settings pick it up mid-frame
        n = $urandom_range(1, 4);
        repeat (n) send_pixel(rand_byte(), rand_byte(), rand_byte(), 1'b0, '0);
      end else begin
        do send_pixel(rand_byte(), rand_byte(), rand_byte(), 1'b0, '0);
        while (!frame_start);
      end
    end

    settle();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
